FILE: src/frra_pkg.sv
// ----------------------------------------------------------------------------
// frra_pkg
// Shared widths, codes and types of the fence-retired ring allocator.
// ----------------------------------------------------------------------------
package frra_pkg;

  localparam int CAP_W    = 11;
  localparam int LEN_W    = 11;
  localparam int FENCE_W  = 64;
  localparam int OFF_W    = 10;

  localparam int DEFAULT_MAX_SLOTS = 1024;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_REL_CHK,
    S_RET_CHK,
    S_RET_RD,
    S_FIT,
    S_PAD_CHK,
    S_PLACE_RD,
    S_PLACE_CHK
  } fsm_state_t;

endpackage

FILE: src/frra_ram.sv
// ----------------------------------------------------------------------------
// frra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/frra_ctrl.sv
// ----------------------------------------------------------------------------
// frra_ctrl
// Sequencer: clearing sweep (writes only); retire walk, pad/wrap, placement
// and release, all as read-modify-write passes over the segment RAM.
// ----------------------------------------------------------------------------
module frra_ctrl
  import frra_pkg::*;
#(
  parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS,
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int KW = ((SW + 1) > CAP_W) ? (SW + 1) : CAP_W,
  localparam int WW = SW + FENCE_W + 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [KW-1:0]      ecap,
  input  logic               start,
  input  logic               cmd,
  input  logic [LEN_W-1:0]   run_length,
  input  logic [FENCE_W-1:0] fence,
  input  logic [OFF_W-1:0]   run_offset,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output logic [OFF_W-1:0]   granted_offset,
  output logic               mem_we,
  output logic [SW-1:0]      mem_waddr,
  output logic [WW-1:0]      mem_wdata,
  output logic [SW-1:0]      mem_raddr,
  input  logic [WW-1:0]      mem_rdata
);

  localparam int VAL_BIT = WW - 1;
  localparam int REL_BIT = WW - 2;
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);

  fsm_state_t state, state_next;

  logic [SW-1:0]      head, head_next;
  logic [SW-1:0]      tail, tail_next;
  logic [SW-1:0]      clr_idx;
  logic               cmd_q;
  logic [KW-1:0]      count_q;
  logic [FENCE_W-1:0] fence_q;
  logic [KW-1:0]      offset_q;
  logic               done_q;
  status_t            status_q;
  logic [OFF_W-1:0]   granted_q;

  logic               res_fire;
  status_t            res_status;
  logic [OFF_W-1:0]   res_offset;

  // segment word fields
  logic               rd_valid;
  logic               rd_rel;
  logic [FENCE_W-1:0] rd_fence;
  logic [SW-1:0]      rd_len;

  logic [KW-1:0] head_k, tail_k, rem, room_lo, room_pad;
  logic [KW:0]   head_sum, head_wrap, tail_sum, tail_wrap;
  logic [SW-1:0] head_adv, tail_adv, off_slot;
  logic          too_large, off_bad, retire_ok, fit_now, need_pad;

  assign rd_valid = mem_rdata[VAL_BIT];
  assign rd_rel   = mem_rdata[REL_BIT];
  assign rd_fence = mem_rdata[SW +: FENCE_W];
  assign rd_len   = mem_rdata[SW-1:0];

  assign head_k   = KW'(head);
  assign tail_k   = KW'(tail);
  assign off_slot = offset_q[SW-1:0];

  assign too_large = count_q > (ecap - KW'(1));
  assign off_bad   = offset_q >= ecap;
  assign retire_ok = rd_valid && rd_rel && (rd_fence <= fence_q);

  // next head after retiring the front segment, mod capacity
  assign head_sum  = (KW + 1)'(head_k) + (KW + 1)'(rd_len);
  assign head_wrap = (head_sum >= (KW + 1)'(ecap)) ? head_sum - (KW + 1)'(ecap) : head_sum;
  assign head_adv  = head_wrap[SW-1:0];

  assign tail_sum  = (KW + 1)'(tail_k) + (KW + 1)'(count_q);
  assign tail_wrap = (tail_sum >= (KW + 1)'(ecap)) ? tail_sum - (KW + 1)'(ecap) : tail_sum;
  assign tail_adv  = tail_wrap[SW-1:0];

  assign rem      = ecap - tail_k;
  assign room_lo  = head_k - tail_k - KW'(1);
  assign room_pad = head_k - KW'(1);

  // room check; head at slot 0 never pads
  always_comb begin
    fit_now  = 1'b0;
    need_pad = 1'b0;
    if (head <= tail) begin
      if (head == '0) begin
        fit_now = (rem - KW'(1)) >= count_q;
      end else if (rem < count_q) begin
        need_pad = 1'b1;
      end else begin
        fit_now = 1'b1;
      end
    end else begin
      fit_now = room_lo >= count_q;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_SLOT) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (cmd_q == CMD_RELEASE) begin
          state_next = off_bad ? S_IDLE : S_REL_CHK;
        end else begin
          state_next = too_large ? S_IDLE : S_RET_CHK;
        end
      end
      S_REL_CHK:   state_next = S_IDLE;
      S_RET_CHK:   state_next = retire_ok ? S_RET_RD : S_FIT;
      S_RET_RD:    state_next = S_RET_CHK;
      S_FIT: begin
        if (fit_now) state_next = S_PLACE_CHK;
        else if (need_pad) state_next = S_PAD_CHK;
        else state_next = S_IDLE;
      end
      S_PAD_CHK:   state_next = (room_pad >= count_q) ? S_PLACE_RD : S_IDLE;
      S_PLACE_RD:  state_next = S_PLACE_CHK;
      S_PLACE_CHK: state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = tail;
    mem_wdata  = '0;
    mem_raddr  = head;
    res_fire   = 1'b0;
    res_status = ST_OK;
    res_offset = '0;
    head_next  = head;
    tail_next  = tail;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      S_DISPATCH: begin
        if (cmd_q == CMD_RELEASE) begin
          mem_raddr = off_slot;
          if (off_bad) begin
            res_fire   = 1'b1;
            res_status = ST_UNKNOWN;
          end
        end else if (too_large) begin
          res_fire   = 1'b1;
          res_status = ST_TOO_LARGE;
        end
      end
      S_REL_CHK: begin
        res_fire = 1'b1;
        if (rd_valid) begin
          mem_we    = 1'b1;
          mem_waddr = off_slot;
          mem_wdata = {1'b1, 1'b1, fence_q, rd_len};
        end else begin
          res_status = ST_UNKNOWN;
        end
      end
      S_RET_CHK: begin
        if (retire_ok) begin
          mem_we    = 1'b1;
          mem_waddr = head;
          head_next = head_adv;
        end
      end
      S_FIT: begin
        mem_raddr = tail;
        if (!fit_now && !need_pad) begin
          res_fire   = 1'b1;
          res_status = ST_FULL;
        end
      end
      S_PAD_CHK: begin
        mem_we    = !rd_valid;
        mem_wdata = {1'b1, 1'b1, {FENCE_W{1'b0}}, rem[SW-1:0]};
        tail_next = '0;
        if (room_pad < count_q) begin
          res_fire   = 1'b1;
          res_status = ST_FULL;
        end
      end
      S_PLACE_RD: begin
        mem_raddr = tail;
      end
      S_PLACE_CHK: begin
        mem_we     = !rd_valid;
        mem_wdata  = {1'b0 ^ 1'b1, 1'b0, {FENCE_W{1'b0}}, count_q[SW-1:0]};
        res_fire   = 1'b1;
        res_offset = tail_k[OFF_W-1:0];
        tail_next  = tail_adv;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      head    <= '0;
      tail    <= '0;
      done_q  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + SW'(1);
      head   <= head_next;
      tail   <= tail_next;
      done_q <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q    <= cmd;
      count_q  <= KW'(run_length);
      fence_q  <= fence;
      offset_q <= KW'(run_offset);
    end
    if (res_fire) begin
      status_q  <= res_status;
      granted_q <= res_offset;
    end
  end

  assign busy           = (state != S_IDLE);
  assign done           = done_q;
  assign status         = status_q;
  assign granted_offset = granted_q;

  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |-> (head_k < ecap && tail_k < ecap))
    else $error("head or tail outside ring");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("segment write while idle");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cfg_we) |=> (state == S_DISPATCH))
    else $error("accepted command not dispatched");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside idle");

endmodule

FILE: src/fence_retired_ring_allocator.sv
// ----------------------------------------------------------------------------
// fence_retired_ring_allocator
// Ring allocator of contiguous slot runs with fence-based retirement.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: present cmd/run_length/fence/run_offset with start; the
//    word is taken on a clock edge with start high and busy low.
//  - Result channel: done pulses for one cycle with status and
//    granted_offset. There is no back-pressure; the receiver must take it.
//  - Config channel: cfg_valid/cfg_ready write ring_capacity (clamped to
//    2..MAX_SLOTS). Each write empties the ring. cfg_ready is always high;
//    write only while idle.
//  - Reset and every capacity write start a sweep over all MAX_SLOTS slots of
//    the segment RAM; busy stays high through it.
// Flow, from the accept edge to the cycle done is high (next accept at that edge):
//  - rejected command: ends at dispatch; release: reads the slot, then
//    writes it back; allocate: retires segments from the head one by one,
//    may pad the tail and wrap, then places the run; an allocate that finds
//    the ring full without padding ends before placement.
//  The pace is set by the segment RAM: one read, then one write-back, per
//  segment visited, with the registered read in between.
// Result order matches command order; one result per command.
// ----------------------------------------------------------------------------
module fence_retired_ring_allocator
  import frra_pkg::*;
#(
  parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [LEN_W-1:0]   run_length,
  input  logic [FENCE_W-1:0] fence,
  input  logic [OFF_W-1:0]   run_offset,
  output logic               done,
  output logic [1:0]         status,
  output logic [OFF_W-1:0]   granted_offset,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CAP_W-1:0]   cfg_data
);

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int KW = ((SW + 1) > CAP_W) ? (SW + 1) : CAP_W;
  localparam int WW = SW + FENCE_W + 2;
  localparam int ECAP_RESET = (int'(CAP_RESET) > MAX_SLOTS) ? MAX_SLOTS : int'(CAP_RESET);

  logic          cfg_we;
  logic [KW-1:0] cap_k;
  logic [KW-1:0] cap_clamped;
  logic [KW-1:0] ecap;     // effective capacity

  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [SW-1:0] mem_raddr;
  logic [WW-1:0] mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // clamp the written value once, at write time
  assign cap_k = KW'(cfg_data);
  always_comb begin
    if (cap_k < KW'(2)) begin
      cap_clamped = KW'(2);
    end else if (cap_k > KW'(MAX_SLOTS)) begin
      cap_clamped = KW'(MAX_SLOTS);
    end else begin
      cap_clamped = cap_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ecap <= KW'(ECAP_RESET);
    end else if (cfg_we) begin
      ecap <= cap_clamped;
    end
  end

  // segment word: {valid, releasable, retire fence, length}
  frra_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_SLOTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  frra_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .ecap           (ecap),
    .start          (start),
    .cmd            (cmd),
    .run_length     (run_length),
    .fence          (fence),
    .run_offset     (run_offset),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .granted_offset (granted_offset),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

endmodule

FILE: dv/fence_retired_ring_allocator_test.sv
// ----------------------------------------------------------------------------
// fence_retired_ring_allocator_test
// Self-checking bench for the fence-retired ring allocator. A queue of
// command words feeds a clocked driver with random gaps. A clocked monitor
// runs a local model of the ring on every accepted word and checks each
// done pulse against the oldest predicted reply. Phases run at several ring
// capacities, from clamped-low through clamped-high.
// ----------------------------------------------------------------------------
module fence_retired_ring_allocator_test;
  import frra_pkg::*;

  localparam int SLOTS      = DEFAULT_MAX_SLOTS;
  localparam int RANDOM_OPS = 400;
  localparam int RUN_LIMIT  = 600000;   // cycles; slowest legal run is far below
  localparam int TAIL_WAIT  = 20;       // cycles to watch for stray results

  typedef struct packed {
    logic               cmd;
    logic [LEN_W-1:0]   len;
    logic [FENCE_W-1:0] fence;
    logic [OFF_W-1:0]   off;
  } ring_op_t;

  typedef struct packed {
    status_t          st;
    logic [OFF_W-1:0] off;
  } ring_reply_t;

  // DUT ports; every input starts at a known value
  logic               clk;
  logic               rst        = 1'b1;
  logic               start      = 1'b0;
  logic               busy;
  logic               cmd        = CMD_ALLOC;
  logic [LEN_W-1:0]   run_length = '0;
  logic [FENCE_W-1:0] fence      = '0;
  logic [OFF_W-1:0]   run_offset = '0;
  logic               done;
  logic [1:0]         status;
  logic [OFF_W-1:0]   granted_offset;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_data   = '0;

  fence_retired_ring_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .run_length     (run_length),
    .fence          (fence),
    .run_offset     (run_offset),
    .done           (done),
    .status         (status),
    .granted_offset (granted_offset),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  ring_op_t    op_queue[$];      // words waiting for the driver
  ring_reply_t replies[$];       // predicted replies, oldest first
  logic        took     = 1'b0;  // the presented word went in at the last edge
  logic        no_gaps  = 1'b0;  // sender never idles while set
  int          faults   = 0;
  int          cycles   = 0;

  // --------------------------------------------------------------------------
  // Ring model: capacity register, per-slot segment table, head and tail
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0]   model_cap = CAP_RESET;
  bit                 model_live  [SLOTS];
  logic [LEN_W-1:0]   model_len   [SLOTS];
  logic [FENCE_W-1:0] model_fence [SLOTS];
  bit                 model_rel   [SLOTS];
  int unsigned        model_head, model_tail;

  function automatic void empty_model();
    for (int s = 0; s < SLOTS; s++) begin
      model_live[s]  = 1'b0;
      model_len[s]   = '0;
      model_fence[s] = '0;
      model_rel[s]   = 1'b0;
    end
    model_head = 0;
    model_tail = 0;
  endfunction

  // capacity as the block uses it: clamped to 2..SLOTS
  function automatic int unsigned usable_slots();
    int unsigned c;
    c = model_cap;
    if (c < 2) c = 2;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  // a slot that already holds a segment keeps the old one
  function automatic void claim_slot(int unsigned slot, int unsigned len, bit rel);
    if (slot >= SLOTS || model_live[slot]) return;
    model_live[slot]  = 1'b1;
    model_len[slot]   = LEN_W'(len);
    model_fence[slot] = '0;
    model_rel[slot]   = rel;
  endfunction

  function automatic ring_reply_t apply_ring_op(ring_op_t op);
    ring_reply_t r;
    int unsigned c, h, room, steps;
    bit          fits, walking;
    r.st = ST_OK;
    r.off = '0;
    c = usable_slots();

    if (op.cmd == CMD_RELEASE) begin
      if (op.off >= c || !model_live[op.off]) begin
        r.st = ST_UNKNOWN;
      end else begin
        model_fence[op.off] = op.fence;
        model_rel[op.off]   = 1'b1;
      end
      return r;
    end

    if (op.len > c - 1) begin
      r.st = ST_TOO_LARGE;
      return r;
    end

    // retire from the head while released and fenced off
    walking = 1'b1;
    steps = 0;
    while (walking && steps < SLOTS) begin
      h = model_head;
      if (h >= c || !model_live[h] || !model_rel[h] || model_fence[h] > op.fence) begin
        walking = 1'b0;
      end else begin
        model_live[h] = 1'b0;
        model_head = (h + model_len[h]) % c;
      end
      steps++;
    end

    fits = 1'b0;
    if (model_head <= model_tail) begin
      room = c - model_tail;
      if (model_head == 0) begin
        fits = (room - 1 >= op.len);
      end else if (room < op.len) begin
        // pad the short tail and wrap, even if the run then misses
        if (room > 0) claim_slot(model_tail, room, 1'b1);
        model_tail = 0;
      end else begin
        fits = 1'b1;
      end
    end
    if (!fits && model_head > model_tail && model_head - model_tail - 1 >= op.len)
      fits = 1'b1;
    if (!fits) begin
      r.st = ST_FULL;
      return r;
    end

    claim_slot(model_tail, op.len, 1'b0);
    r.off = OFF_W'(model_tail);
    model_tail = (model_tail + op.len) % c;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: moves on at the falling edge once the word went in (or nothing
  // was up). A held word is never dropped and re-raised in one step.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    ring_op_t next_word;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (op_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 38)) begin
        next_word  = op_queue.pop_front();
        start      <= 1'b1;
        cmd        <= next_word.cmd;
        run_length <= next_word.len;
        fence      <= next_word.fence;
        run_offset <= next_word.off;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the result first (it belongs to an older word), then
  // predict for a word accepted at this same edge, then track config writes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    ring_reply_t want;
    ring_op_t    seen;
    took <= start && !busy && !rst;
    if (!rst) begin
      if (done) begin
        if (replies.size() == 0) begin
          $display("%0t: result with nothing pending: expected none, got status %0d offset %0d",
                   $time, status, granted_offset);
          faults++;
        end else begin
          want = replies.pop_front();
          if (status !== want.st) begin
            $display("%0t: status expected %0d got %0d", $time, want.st, status);
            faults++;
          end
          if (granted_offset !== want.off) begin
            $display("%0t: granted_offset expected %0d got %0d",
                     $time, want.off, granted_offset);
            faults++;
          end
        end
      end
      if (start && !busy) begin
        seen.cmd   = cmd;
        seen.len   = run_length;
        seen.fence = fence;
        seen.off   = run_offset;
        replies = {replies, apply_ring_op(seen)};
      end
      if (cfg_valid && cfg_ready) begin
        model_cap = cfg_data;
        empty_model();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_op(logic c, int unsigned len, logic [FENCE_W-1:0] f, int unsigned off);
    ring_op_t w;
    w.cmd   = c;
    w.len   = LEN_W'(len);
    w.fence = f;
    w.off   = OFF_W'(off);
    op_queue = {op_queue, w};
  endtask

  // idle: nothing queued, nothing up, nothing owed, clearing sweep over
  task automatic settle();
    do @(negedge clk);
    while (busy || start || op_queue.size() != 0 || replies.size() != 0);
  endtask

  // called right after settle(), at a falling edge
  task automatic write_capacity(logic [CAP_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocates at a rising completed fence and
  // releases of live runs, with some noise (random offsets, wild fences,
  // oversize lengths). Kept a few words ahead of the driver so the picks
  // follow the model closely.
  task automatic random_ops(int n, ref int made, input logic [FENCE_W-1:0] base);
    logic [FENCE_W-1:0] done_fence;
    int unsigned        c, len, sel;
    int                 picks[$];
    done_fence = base;
    for (int k = 0; k < n; k++) begin
      wait (op_queue.size() < 4);
      no_gaps = (made >= 150 && made < 230);
      c = usable_slots();
      sel = $urandom_range(99);
      if (sel < 45) begin
        sel = $urandom_range(99);
        if (sel < 5)       len = $urandom_range(0, 1024);
        else if (sel < 12) len = c - 1;
        else               len = $urandom_range(0, (c > 8) ? c / 4 : c - 1);
        queue_op(CMD_ALLOC, len, done_fence, $urandom_range(0, 1023));
        done_fence = done_fence + $urandom_range(0, 2);
      end else if (sel < 85) begin
        picks.delete();
        for (int s = 0; s < c; s++)
          if (model_live[s] && !model_rel[s]) picks = {picks, s};
        queue_op(CMD_RELEASE, $urandom_range(0, 1024), done_fence + $urandom_range(0, 4),
                 (picks.size() != 0) ? picks[$urandom_range(0, picks.size() - 1)]
                                     : $urandom_range(0, c - 1));
      end else begin
        queue_op($urandom_range(0, 1), $urandom_range(0, 1024), {$urandom, $urandom},
                 $urandom_range(0, 1023));
      end
      made++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    logic [CAP_W-1:0] caps[7];
    int               made;
    made = 0;
    caps = '{11'd2, 11'd1, 11'd7, 11'd37, 11'd2047, 11'd1024, 11'd0};
    caps[6] = CAP_W'($urandom_range(3, 1023));
    empty_model();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    settle();

    // reset capacity (1024)
    queue_op(CMD_ALLOC,   1024, '0, 0);      // one over capacity-1
    queue_op(CMD_ALLOC,   0,    '0, 1023);   // zero-length run at slot 0
    queue_op(CMD_ALLOC,   5,    '0, 0);      // lands on the zero-length segment
    queue_op(CMD_RELEASE, 0,    '0, 1023);   // nothing there
    queue_op(CMD_RELEASE, 1024, '1, 0);      // fence all ones
    queue_op(CMD_ALLOC,   1023, '0, 0);      // head at 0: no room, full
    queue_op(CMD_RELEASE, 0,    64'd3, 0);
    queue_op(CMD_ALLOC,   10,   64'd3, 0);   // retires the zero-length segment
    settle();

    // capacity 0 behaves as 2
    write_capacity(11'd0);
    queue_op(CMD_ALLOC,   1, '0, 0);
    queue_op(CMD_ALLOC,   1, '0, 0);         // head at 0 with one slot left
    queue_op(CMD_ALLOC,   2, '0, 0);         // too large for two slots
    queue_op(CMD_RELEASE, 0, '0, 2);         // offset past capacity
    queue_op(CMD_RELEASE, 0, '0, 0);
    queue_op(CMD_ALLOC,   1, '0, 0);         // retire, place, tail wraps to 0
    queue_op(CMD_RELEASE, 0, 64'd7, 1);
    queue_op(CMD_ALLOC,   1, 64'd6, 0);      // fence not reached yet
    queue_op(CMD_ALLOC,   1, 64'd7, 0);
    settle();

    // capacity 10: tail padding, on a full ring and on a good wrap
    write_capacity(11'd10);
    queue_op(CMD_ALLOC,   6, '0, 0);
    queue_op(CMD_RELEASE, 0, 64'd1, 0);
    queue_op(CMD_ALLOC,   6, 64'd1, 0);      // pads 6..9, wraps, still full
    queue_op(CMD_ALLOC,   5, 64'd1, 0);      // pad retires, run at 0
    queue_op(CMD_RELEASE, 0, 64'd2, 0);
    queue_op(CMD_ALLOC,   3, 64'd2, 0);
    queue_op(CMD_ALLOC,   4, 64'd2, 0);      // pads 8..9, run fits at 0
    settle();

    // random phases; odd ones run fences near the top of the range
    for (int p = 0; p < 7; p++) begin
      write_capacity(caps[p]);
      random_ops(RANDOM_OPS / 7 + 1, made, (p % 2) ? 64'hFFFF_FFFF_FFFF_F000 : '0);
      settle();
    end
    no_gaps = 1'b0;

    repeat (TAIL_WAIT) @(posedge clk);
    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/frra_pkg.sv
src/frra_ram.sv
src/frra_ctrl.sv
src/fence_retired_ring_allocator.sv
dv/fence_retired_ring_allocator_test.sv
